>>> rtl/core/kprd_pkg.sv
package kprd_pkg;

  localparam int unsigned KEYS_W = 7;
  localparam int unsigned HOLD_W = 9;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned CFG_W = 8;
  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [HOLD_W-1:0] HOLD_MAX = {HOLD_W{1'b1}};
  localparam logic [KEYS_W-1:0] KEYS_RELEASED = {KEYS_W{1'b1}};

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_HOLD = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FAST_REPEAT = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FAST_AFTER = 8'd3;

  // Register reset values.
  localparam logic [CFG_W-1:0] FIRST_HOLD_RESET = 8'd32;
  localparam logic [CFG_W-1:0] REPEAT_RESET = 8'd16;
  localparam logic [CFG_W-1:0] FAST_REPEAT_RESET = 8'd4;
  localparam logic [CFG_W-1:0] FAST_AFTER_RESET = 8'd10;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CONFIRM = 2'd1,
    PH_RELEASE = 2'd2,
    PH_UNUSED = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG = 2'd2
  } event_t;

  typedef struct packed {
    logic [CFG_W-1:0] first_hold_ticks;
    logic [CFG_W-1:0] repeat_ticks;
    logic [CFG_W-1:0] fast_repeat_ticks;
    logic [CFG_W-1:0] fast_after_count;
  } cfg_t;

  typedef struct packed {
    phase_t phase;
    logic held_flag;
    logic [HOLD_W-1:0] hold_ticks;
    logic [COUNT_W-1:0] repeat_count;
    logic [2:0] latched_key;
  } state_t;

  typedef struct packed {
    event_t event_kind;
    logic [2:0] key_code;
    logic fast_mode;
  } result_t;

endpackage

>>> rtl/core/kprd_step.sv
// One scan tick of the detector: next machine state and the result item.
module kprd_step (
  input  kprd_pkg::state_t st,
  input  kprd_pkg::cfg_t cfg,
  input  logic [kprd_pkg::KEYS_W-1:0] keys_n,
  output kprd_pkg::state_t st_next,
  output kprd_pkg::result_t res
);

  logic pressed;
  logic [2:0] pick;
  logic [kprd_pkg::HOLD_W-1:0] hold;
  logic [kprd_pkg::COUNT_W-1:0] count;
  logic held;
  kprd_pkg::event_t ev;
  kprd_pkg::phase_t phase_next;

  assign pressed = keys_n != kprd_pkg::KEYS_RELEASED;

  // Fixed priority: the lowest low pin wins.
  always_comb begin
    pick = 3'd0;
    for (int b = kprd_pkg::KEYS_W - 1; b >= 0; b--) begin
      if (!keys_n[b]) begin
        pick = 3'(b + 1);
      end
    end
  end

  // Next phase.
  always_comb begin
    phase_next = st.phase;
    unique case (st.phase)
      kprd_pkg::PH_CONFIRM: begin
        if (!pressed) begin
          phase_next = st.held_flag ? kprd_pkg::PH_RELEASE : kprd_pkg::PH_IDLE;
        end
      end
      kprd_pkg::PH_RELEASE: begin
        if (!pressed) begin
          phase_next = kprd_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_next = pressed ? kprd_pkg::PH_CONFIRM : kprd_pkg::PH_IDLE;
      end
    endcase
  end

  // Hold counting, repeat events and the result item.
  always_comb begin
    hold = st.hold_ticks;
    count = st.repeat_count;
    held = st.held_flag;
    ev = kprd_pkg::EV_NONE;
    st_next.phase = phase_next;
    st_next.latched_key = st.latched_key;
    unique case (st.phase)
      kprd_pkg::PH_CONFIRM: begin
        if (pressed) begin
          st_next.latched_key = pick;
          held = 1'b1;
          if (hold != kprd_pkg::HOLD_MAX) begin
            hold = hold + 1'b1;
          end
          // First long event after the initial hold.
          if (count == '0 && hold > {1'b0, cfg.first_hold_ticks}) begin
            ev = kprd_pkg::EV_LONG;
            hold = '0;
            held = 1'b0;
            count = count + 1'b1;
          end
          // Slow repeats count up; fast repeats keep the count.
          if (count < cfg.fast_after_count && count != '0) begin
            if (hold > {1'b0, cfg.repeat_ticks}) begin
              ev = kprd_pkg::EV_LONG;
              hold = '0;
              held = 1'b0;
              count = count + 1'b1;
            end
          end else if (count >= cfg.fast_after_count) begin
            if (hold > {1'b0, cfg.fast_repeat_ticks}) begin
              ev = kprd_pkg::EV_LONG;
              hold = '0;
              held = 1'b0;
            end
          end
        end else begin
          count = '0;
          if (st.held_flag) begin
            ev = kprd_pkg::EV_SHORT;
          end
        end
      end
      kprd_pkg::PH_RELEASE: begin
      end
      default: begin
        hold = '0;
        held = 1'b0;
      end
    endcase
    st_next.hold_ticks = hold;
    st_next.repeat_count = count;
    st_next.held_flag = held;
    res.event_kind = ev;
    res.key_code = st_next.latched_key;
    res.fast_mode = count >= cfg.fast_after_count;
  end

endmodule

>>> rtl/core/keypad_press_repeat_detector.sv
// Keypad press, long-press and auto-repeat detector. Each s_tdata transfer is
// one scan tick carrying the seven active-low key pins, and each tick yields
// exactly one result transfer on the m side: the event (none, short press, or
// long/repeat), the latched key code and the fast-repeat flag. A tick goes
// through an input register and a result register, so its result is offered
// once the tick moves from the input register into the result register,
// and a new tick is taken in every cycle while the result side keeps up.
// Timing registers are written over the cfg channel, which is always ready;
// writes to indexes beyond 3 are dropped.
module keypad_press_repeat_detector (
  input  logic clk,
  input  logic rst,
  // Scan ticks in.
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [7:0] s_tdata,    // [6:0] keys_n, [7] zero
  // Results out.
  output logic m_tvalid,
  input  logic m_tready,
  output logic [7:0] m_tdata,    // [2:0] key_code, [3] fast_mode, [7:4] zero
  output logic [1:0] m_tuser,    // [1:0] event_kind
  // Register writes.
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [kprd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kprd_pkg::CFG_W-1:0] cfg_data
);

  kprd_pkg::cfg_t cfg;
  kprd_pkg::state_t st;
  kprd_pkg::state_t st_next;
  kprd_pkg::result_t res_next;
  kprd_pkg::result_t res;
  logic in_valid;
  logic [kprd_pkg::KEYS_W-1:0] in_keys;
  logic advance;

  // A tick advances when the result register is free or being emptied.
  assign advance = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_hold_ticks <= kprd_pkg::FIRST_HOLD_RESET;
      cfg.repeat_ticks <= kprd_pkg::REPEAT_RESET;
      cfg.fast_repeat_ticks <= kprd_pkg::FAST_REPEAT_RESET;
      cfg.fast_after_count <= kprd_pkg::FAST_AFTER_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        kprd_pkg::CFG_FIRST_HOLD: cfg.first_hold_ticks <= cfg_data;
        kprd_pkg::CFG_REPEAT: cfg.repeat_ticks <= cfg_data;
        kprd_pkg::CFG_FAST_REPEAT: cfg.fast_repeat_ticks <= cfg_data;
        kprd_pkg::CFG_FAST_AFTER: cfg.fast_after_count <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_keys <= s_tdata[kprd_pkg::KEYS_W-1:0];
    end
  end

  kprd_step u_step (
    .st      (st),
    .cfg     (cfg),
    .keys_n  (in_keys),
    .st_next (st_next),
    .res     (res_next)
  );

  // Machine state moves on with each tick that reaches the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase <= kprd_pkg::PH_IDLE;
      st.held_flag <= 1'b0;
      st.hold_ticks <= '0;
      st.repeat_count <= '0;
      st.latched_key <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_tdata = {4'b0000, res.fast_mode, res.key_code};
  assign m_tuser = res.event_kind;

endmodule
